FILE: sv/gfifft_pkg.sv
// Shared types, register indexes and GF(2^8) arithmetic for the radix-8 IFFT butterfly.
package gfifft_pkg;

    typedef logic [7:0] t_byte;
    typedef t_byte [7:0] t_pts;

    localparam int unsigned NumRegs = 8;
    localparam int unsigned CfgIdxW = $clog2(NumRegs);
    localparam t_byte       PolyReset = 8'h1d;

    typedef enum logic [CfgIdxW-1:0] {
        REG_COEF_LOW_A = 3'd0,
        REG_COEF_LOW_B = 3'd1,
        REG_COEF_LOW_C = 3'd2,
        REG_COEF_LOW_D = 3'd3,
        REG_COEF_MID_A = 3'd4,
        REG_COEF_MID_B = 3'd5,
        REG_COEF_TOP   = 3'd6,
        REG_FIELD_POLY = 3'd7
    } t_reg_idx;

    // Polynomial-basis product modulo x^8 + poly.
    function automatic t_byte fmul(t_byte a, t_byte b, t_byte poly);
        t_byte acc;
        t_byte m;
        acc = '0;
        m   = a;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                acc = acc ^ m;
            end
            m = {m[6:0], 1'b0} ^ (m[7] ? poly : 8'h00);
        end
        return acc;
    endfunction

    // x half of a butterfly, given the already updated y; a zero coefficient yields x.
    function automatic t_byte bfly_x(t_byte x, t_byte y_new, t_byte c, t_byte poly);
        return x ^ fmul(y_new, c, poly);
    endfunction

endpackage

FILE: sv/gfifft_in_if.sv
// Input channel: eight shard bytes and the last flag.
interface gfifft_in_if;
    logic                   valid;
    logic                   ready;
    gfifft_pkg::t_byte      point_0;
    gfifft_pkg::t_byte      point_1;
    gfifft_pkg::t_byte      point_2;
    gfifft_pkg::t_byte      point_3;
    gfifft_pkg::t_byte      point_4;
    gfifft_pkg::t_byte      point_5;
    gfifft_pkg::t_byte      point_6;
    gfifft_pkg::t_byte      point_7;
    logic                   last_in;

    modport source (
        output valid, point_0, point_1, point_2, point_3,
               point_4, point_5, point_6, point_7, last_in,
        input  ready
    );
    modport sink (
        input  valid, point_0, point_1, point_2, point_3,
               point_4, point_5, point_6, point_7, last_in,
        output ready
    );
endinterface

FILE: sv/gfifft_out_if.sv
// Output channel: eight transformed bytes and the last flag.
interface gfifft_out_if;
    logic                   valid;
    logic                   ready;
    gfifft_pkg::t_byte      result_0;
    gfifft_pkg::t_byte      result_1;
    gfifft_pkg::t_byte      result_2;
    gfifft_pkg::t_byte      result_3;
    gfifft_pkg::t_byte      result_4;
    gfifft_pkg::t_byte      result_5;
    gfifft_pkg::t_byte      result_6;
    gfifft_pkg::t_byte      result_7;
    logic                   last_out;

    modport source (
        output valid, result_0, result_1, result_2, result_3,
               result_4, result_5, result_6, result_7, last_out,
        input  ready
    );
    modport sink (
        input  valid, result_0, result_1, result_2, result_3,
               result_4, result_5, result_6, result_7, last_out,
        output ready
    );
endinterface

FILE: sv/gf256_radix8_ifft_butterfly_unit.sv
// Three-stage pipelined radix-8 inverse additive-FFT butterfly over GF(2^8).
// One item (eight shard bytes at one position) is accepted per cycle while
// input ready is high. Each butterfly stage of the transform is one register
// stage (r_d1, r_d2, r_d3) holding four GF(2^8) multipliers, so throughput is
// one item per clock while the output is taken. The stages form an elastic
// pipeline: an empty stage takes a new item even while the output is stalled,
// and input ready drops only when all three stages are full and the output is
// not taken. The user writes coefficients and the reduction polynomial via the
// configuration port only while the pipeline is empty; no logic enforces this.
module gf256_radix8_ifft_butterfly_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gfifft_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  gfifft_pkg::t_byte                 i_cfg_data,
    gfifft_in_if.sink                         i_in,
    gfifft_out_if.source                      o_out
);
    import gfifft_pkg::*;

    t_byte r_coef_low [4];
    t_byte r_coef_mid [2];
    t_byte r_coef_top;
    t_byte r_poly;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 4; j++) r_coef_low[j] <= '0;
            for (int j = 0; j < 2; j++) r_coef_mid[j] <= '0;
            r_coef_top <= '0;
            r_poly     <= PolyReset;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_COEF_LOW_A: r_coef_low[0] <= i_cfg_data;
                REG_COEF_LOW_B: r_coef_low[1] <= i_cfg_data;
                REG_COEF_LOW_C: r_coef_low[2] <= i_cfg_data;
                REG_COEF_LOW_D: r_coef_low[3] <= i_cfg_data;
                REG_COEF_MID_A: r_coef_mid[0] <= i_cfg_data;
                REG_COEF_MID_B: r_coef_mid[1] <= i_cfg_data;
                REG_COEF_TOP:   r_coef_top    <= i_cfg_data;
                REG_FIELD_POLY: r_poly        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline registers
    logic r_v1, r_v2, r_v3;
    logic r_l1, r_l2, r_l3;
    t_pts r_d1, r_d2, r_d3;
    t_pts n_d1, n_d2, n_d3;
    t_pts w_in;
    logic w_ld1, w_ld2, w_ld3;
    logic w_rdy1, w_rdy2, w_rdy3;

    assign w_in = {i_in.point_7, i_in.point_6, i_in.point_5, i_in.point_4,
                   i_in.point_3, i_in.point_2, i_in.point_1, i_in.point_0};

    // A stage can load when it is empty or its content moves on this cycle.
    assign w_rdy3 = !r_v3 || o_out.ready;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign w_ld1  = i_in.valid && w_rdy1;
    assign w_ld2  = r_v1 && w_rdy2;
    assign w_ld3  = r_v2 && w_rdy3;
    assign i_in.ready = w_rdy1;

    // Stage one: pairs (0,1)(2,3)(4,5)(6,7)
    always_comb begin
        n_d1 = w_in;
        for (int j = 0; j < 4; j++) begin
            n_d1[2*j+1] = w_in[2*j+1] ^ w_in[2*j];
            n_d1[2*j]   = bfly_x(w_in[2*j], n_d1[2*j+1], r_coef_low[j], r_poly);
        end
    end

    // Stage two: pairs (0,2)(1,3) and (4,6)(5,7)
    always_comb begin
        n_d2 = r_d1;
        for (int g = 0; g < 2; g++) begin
            for (int k = 0; k < 2; k++) begin
                n_d2[4*g+k+2] = r_d1[4*g+k+2] ^ r_d1[4*g+k];
                n_d2[4*g+k]   = bfly_x(r_d1[4*g+k], n_d2[4*g+k+2], r_coef_mid[g], r_poly);
            end
        end
    end

    // Stage three: pairs (i, i+4)
    always_comb begin
        n_d3 = r_d2;
        for (int k = 0; k < 4; k++) begin
            n_d3[k+4] = r_d2[k+4] ^ r_d2[k];
            n_d3[k]   = bfly_x(r_d2[k], n_d3[k+4], r_coef_top, r_poly);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_in.valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld1) begin
            r_d1 <= n_d1;
            r_l1 <= i_in.last_in;
        end
        if (w_ld2) begin
            r_d2 <= n_d2;
            r_l2 <= r_l1;
        end
        if (w_ld3) begin
            r_d3 <= n_d3;
            r_l3 <= r_l2;
        end
    end

    assign o_out.valid    = r_v3;
    assign o_out.result_0 = r_d3[0];
    assign o_out.result_1 = r_d3[1];
    assign o_out.result_2 = r_d3[2];
    assign o_out.result_3 = r_d3[3];
    assign o_out.result_4 = r_d3[4];
    assign o_out.result_5 = r_d3[5];
    assign o_out.result_6 = r_d3[6];
    assign o_out.result_7 = r_d3[7];
    assign o_out.last_out = r_l3;

    // Input back-pressure only when every stage holds an item.
    a_full_when_blocked : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_v1 && r_v2 && r_v3 && !o_out.ready))
        else $error("input blocked while pipeline has room");

    // A middle stage that cannot drain keeps its item.
    a_mid_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_v3 && !o_out.ready) |=> (r_v2 && $stable(r_d2) && $stable(r_l2)))
        else $error("stalled stage two lost or changed its item");

    // An accepted item reaches stage one on the next edge.
    a_enter : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_v1)
        else $error("accepted item did not enter the pipeline");

endmodule
